### src/averaged_pi_temperature_controller_unit_assert.svh
// Assertion helpers, clocked on i_clk, disabled while i_rst_n is low.
`ifndef AVERAGED_PI_TEMPERATURE_CONTROLLER_UNIT_ASSERT_SVH
`define AVERAGED_PI_TEMPERATURE_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define APTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define APTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/aptc_pkg.sv
`timescale 1ns / 1ps

package aptc_pkg;

    localparam int WINDOW     = 20;
    localparam int POS_W      = $clog2(WINDOW);
    localparam int SUM_W      = 16 + $clog2(WINDOW);
    localparam int XF_W       = SUM_W + 4;
    localparam int DF         = 80 * WINDOW;
    localparam int S_AVG      = SUM_W + $clog2(WINDOW);
    localparam int S_F        = XF_W + $clog2(DF);
    localparam int A_W        = SUM_W + 5;
    localparam int B_W        = SUM_W + 5;
    localparam int P_W        = A_W + B_W + 1;

    localparam logic [63:0]    M_AVG_FULL = (64'd1 << S_AVG) / WINDOW;
    localparam logic [63:0]    M_F_FULL   = (64'd1 << S_F) / DF;
    localparam logic [A_W-1:0] M_AVG      = M_AVG_FULL[A_W-1:0];
    localparam logic [A_W-1:0] M_F        = M_F_FULL[A_W-1:0];

    localparam int FRAC_INT   = 17;
    localparam int FRAC_DUTY  = 12;
    localparam int ERR_W      = 17;
    localparam int INTEG_W    = 48;
    localparam int INT_SUM_W  = 50;
    localparam int INC_W      = 36;
    localparam int HALF_W     = 24;
    localparam int LO_W       = 40;
    localparam int HP_W       = 41;
    localparam int ITERM_W    = HP_W + 4;
    localparam int PT_W       = 30;
    localparam int DUTY_W     = 10 + FRAC_DUTY;
    localparam int NX_W       = 47;
    localparam int TDATA_W    = 40;
    localparam int TUSER_W    = 3;

    localparam logic signed [INT_SUM_W-1:0] INT_FLOOR =
        -(INT_SUM_W'(1) <<< (INTEG_W - 1));

    typedef enum logic [1:0] {
        PH_FILL   = 2'd0,
        PH_CHOSEN = 2'd1,
        PH_REG    = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        CFG_SETPOINT   = 3'd0,
        CFG_PROP_GAIN  = 3'd1,
        CFG_INTEG_GAIN = 3'd2,
        CFG_PERIOD     = 3'd3,
        CFG_INT_LIMIT  = 3'd4,
        CFG_HEAT_LIM   = 3'd5,
        CFG_COOL_LIM   = 3'd6
    } t_cfg_idx;

endpackage

### src/averaged_pi_temperature_controller_unit.sv
`timescale 1ns / 1ps

// Averaged PI temperature controller. Each raw sample (1/16 degC) enters a
// WINDOW-deep ring with a running sum. During the first WINDOW-1 samples the
// result is all zeros (phase 0); the sample that fills the ring picks heating
// or cooling from the window average (phase 1); each later sample runs one
// incremental PI step (phase 2) and returns duty, average and Fahrenheit
// digits. One shared multiplier under a sequencer does the wide products. Once
// ST_IDLE takes a sample, the sequencer goes to ST_DONE (filling), or steps
// ST_MUL_AVG to ST_DIGITS (mode choice) or on to ST_DUTY (PI step); ST_DONE
// loads the output register once it is free. A new sample is taken while the
// old result still waits on the output side. The user is to write registers
// through the cfg channel only while the block is idle; nothing enforces it.

`include "averaged_pi_temperature_controller_unit_assert.svh"

module averaged_pi_temperature_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] raw_sample
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [9:0] duty, [25:10] average_temp, [29:26] tens_digit, [33:30] ones_digit
    output logic [aptc_pkg::TDATA_W-1:0] o_m_axis_tdata,
    // [1:0] phase, [2] heating
    output logic [aptc_pkg::TUSER_W-1:0] o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_AVG,
        ST_MUL_F,
        ST_CHK_AVG,
        ST_FIX_AVG,
        ST_FIX_F,
        ST_DIGITS,
        ST_INTEG,
        ST_PROP,
        ST_ILO,
        ST_IHI,
        ST_DUTY,
        ST_DONE
    } t_state;

    t_state r_state;

    logic [15:0] r_setpoint, r_pgain, r_igain, r_period, r_ilimit;
    logic [9:0]  r_heat_lim, r_cool_lim;

    logic [15:0]                   r_ring [aptc_pkg::WINDOW];
    logic [aptc_pkg::POS_W-1:0]    r_wpos;
    logic                          r_filled;
    logic                          r_just;
    logic [aptc_pkg::SUM_W-1:0]    r_sum;
    logic                          r_heat;
    logic signed [aptc_pkg::INTEG_W-1:0] r_integ;
    logic signed [aptc_pkg::ERR_W-1:0]   r_last_err;
    logic signed [aptc_pkg::ERR_W-1:0]   r_err;
    logic [aptc_pkg::DUTY_W-1:0]   r_duty_acc;

    logic signed [aptc_pkg::P_W-1:0]     r_prod;
    logic [15:0]                         r_avg;
    logic [15:0]                         r_fq;
    logic [7:0]                          r_fahr;
    logic [3:0]                          r_tens, r_ones;
    logic [aptc_pkg::LO_W-1:0]           r_lo;
    logic signed [aptc_pkg::PT_W-1:0]    r_pterm;
    logic signed [aptc_pkg::ITERM_W-1:0] r_iterm;
    aptc_pkg::t_phase                    r_phase;

    logic             r_ovalid;
    aptc_pkg::t_phase r_o_phase;
    logic             r_o_heat;
    logic [9:0]       r_o_duty;
    logic [15:0]      r_o_avg;
    logic [3:0]       r_o_tens, r_o_ones;

    // shared multiplier
    logic [aptc_pkg::A_W-1:0]          mul_a;
    logic signed [aptc_pkg::B_W-1:0]   mul_b;
    logic signed [aptc_pkg::P_W-1:0]   mul_p;

    logic                          in_acc;
    logic [15:0]                   old_smp;
    logic [aptc_pkg::SUM_W-1:0]    n_sum;
    logic                          wpos_last;
    logic [aptc_pkg::POS_W-1:0]    n_wpos;
    logic [aptc_pkg::XF_W-1:0]     sum9;
    logic [aptc_pkg::SUM_W-1:0]    rem_avg;
    logic [aptc_pkg::XF_W-1:0]     rem_f;
    logic [15:0]                   fq_fix;
    logic signed [aptc_pkg::ERR_W-1:0]     err_raw;
    logic signed [aptc_pkg::INT_SUM_W-1:0] isum, itop;
    logic signed [aptc_pkg::NX_W-1:0]      nx, ncap;
    logic [9:0]                    cap_lim;
    logic [15:0]                   dig_mul;
    logic [4:0]                    dig_t;
    logic [7:0]                    dig_ones;
    logic [3:0]                    dig_tens;
    logic                          out_free;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign out_free        = !r_ovalid || i_m_axis_tready;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MUL_AVG: begin
                mul_a = aptc_pkg::M_AVG;
                mul_b = aptc_pkg::B_W'(r_sum);
            end
            ST_MUL_F: begin
                mul_a = aptc_pkg::M_F;
                mul_b = aptc_pkg::B_W'(sum9);
            end
            ST_CHK_AVG: begin
                mul_a = aptc_pkg::A_W'(aptc_pkg::WINDOW);
                mul_b = aptc_pkg::B_W'(r_avg);
            end
            ST_FIX_AVG: begin
                mul_a = aptc_pkg::A_W'(aptc_pkg::DF);
                mul_b = aptc_pkg::B_W'(r_fq);
            end
            ST_DIGITS: begin
                mul_a = aptc_pkg::A_W'(r_period);
                mul_b = aptc_pkg::B_W'(r_last_err) + aptc_pkg::B_W'(r_err);
            end
            ST_INTEG: begin
                mul_a = aptc_pkg::A_W'(r_pgain);
                mul_b = aptc_pkg::B_W'(r_err);
            end
            ST_PROP: begin
                mul_a = aptc_pkg::A_W'(r_igain);
                mul_b = aptc_pkg::B_W'({1'b0, r_integ[aptc_pkg::HALF_W-1:0]});
            end
            ST_ILO: begin
                mul_a = aptc_pkg::A_W'(r_igain);
                mul_b = aptc_pkg::B_W'($signed(
                    r_integ[aptc_pkg::INTEG_W-1:aptc_pkg::HALF_W]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    always_comb begin
        old_smp   = r_filled ? r_ring[r_wpos] : 16'd0;
        n_sum     = r_sum - aptc_pkg::SUM_W'(old_smp) + aptc_pkg::SUM_W'(i_s_axis_tdata);
        wpos_last = (r_wpos == aptc_pkg::POS_W'(aptc_pkg::WINDOW - 1));
        n_wpos    = wpos_last ? '0 : r_wpos + 1'b1;

        sum9    = {r_sum, 3'b000} + aptc_pkg::XF_W'(r_sum);
        rem_avg = r_sum - r_prod[aptc_pkg::SUM_W-1:0];
        rem_f   = sum9 - r_prod[aptc_pkg::XF_W-1:0];
        fq_fix  = (rem_f >= aptc_pkg::XF_W'(aptc_pkg::DF)) ? r_fq + 16'd1 : r_fq;

        err_raw = $signed({1'b0, r_setpoint}) - $signed({1'b0, r_avg});

        isum = aptc_pkg::INT_SUM_W'(r_integ)
             + aptc_pkg::INT_SUM_W'($signed(r_prod[aptc_pkg::INC_W-1:0]));
        itop = aptc_pkg::INT_SUM_W'({r_ilimit, {aptc_pkg::FRAC_INT{1'b0}}});

        cap_lim = r_heat ? r_heat_lim : r_cool_lim;
        ncap    = aptc_pkg::NX_W'({cap_lim, {aptc_pkg::FRAC_DUTY{1'b0}}});
        nx      = aptc_pkg::NX_W'($signed({1'b0, r_duty_acc}))
                + aptc_pkg::NX_W'(r_pterm) + aptc_pkg::NX_W'(r_iterm);

        dig_mul  = 16'(r_fahr) * 16'd205;
        dig_t    = dig_mul[15:11];
        dig_ones = r_fahr - 8'(dig_t) * 8'd10;
        if (dig_t >= 5'd20) begin
            dig_tens = 4'(dig_t - 5'd20);
        end else if (dig_t >= 5'd10) begin
            dig_tens = 4'(dig_t - 5'd10);
        end else begin
            dig_tens = 4'(dig_t);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;

        if (in_acc) begin
            r_ring[r_wpos] <= i_s_axis_tdata;
        end

        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_setpoint <= 16'd240;
            r_pgain    <= 16'd1638;
            r_igain    <= 16'd1638;
            r_period   <= 16'd8520;
            r_ilimit   <= 16'd320;
            r_heat_lim <= 10'd256;
            r_cool_lim <= 10'd1023;
            r_wpos     <= '0;
            r_filled   <= 1'b0;
            r_just     <= 1'b0;
            r_sum      <= '0;
            r_heat     <= 1'b0;
            r_integ    <= '0;
            r_last_err <= '0;
            r_duty_acc <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (aptc_pkg::t_cfg_idx'(i_cfg_index))
                    aptc_pkg::CFG_SETPOINT:   r_setpoint <= i_cfg_data;
                    aptc_pkg::CFG_PROP_GAIN:  r_pgain    <= i_cfg_data;
                    aptc_pkg::CFG_INTEG_GAIN: r_igain    <= i_cfg_data;
                    aptc_pkg::CFG_PERIOD:     r_period   <= i_cfg_data;
                    aptc_pkg::CFG_INT_LIMIT:  r_ilimit   <= i_cfg_data;
                    aptc_pkg::CFG_HEAT_LIM:   r_heat_lim <= i_cfg_data[9:0];
                    aptc_pkg::CFG_COOL_LIM:   r_cool_lim <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end

            // in ST_DONE a taken item is replaced by the next one below
            if (r_ovalid && i_m_axis_tready && (r_state != ST_DONE)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_sum    <= n_sum;
                        r_wpos   <= n_wpos;
                        r_just   <= wpos_last && !r_filled;
                        r_filled <= r_filled || wpos_last;
                        if (r_filled || wpos_last) begin
                            r_state <= ST_MUL_AVG;
                        end else begin
                            r_phase <= aptc_pkg::PH_FILL;
                            r_avg   <= '0;
                            r_tens  <= '0;
                            r_ones  <= '0;
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_MUL_AVG: begin
                    r_state <= ST_MUL_F;
                end
                ST_MUL_F: begin
                    r_avg   <= r_prod[aptc_pkg::S_AVG +: 16];
                    r_state <= ST_CHK_AVG;
                end
                ST_CHK_AVG: begin
                    r_fq    <= r_prod[aptc_pkg::S_F +: 16];
                    r_state <= ST_FIX_AVG;
                end
                ST_FIX_AVG: begin
                    if (rem_avg >= aptc_pkg::SUM_W'(aptc_pkg::WINDOW)) begin
                        r_avg <= r_avg + 16'd1;
                    end
                    r_state <= ST_FIX_F;
                end
                ST_FIX_F: begin
                    r_fahr <= fq_fix[7:0] + 8'd32;
                    if (r_just) begin
                        r_heat <= (r_avg < r_setpoint);
                    end
                    r_err   <= r_heat ? err_raw : -err_raw;
                    r_state <= ST_DIGITS;
                end
                ST_DIGITS: begin
                    r_tens <= dig_tens;
                    r_ones <= dig_ones[3:0];
                    if (r_just) begin
                        r_phase <= aptc_pkg::PH_CHOSEN;
                        r_state <= ST_DONE;
                    end else begin
                        r_phase <= aptc_pkg::PH_REG;
                        r_state <= ST_INTEG;
                    end
                end
                ST_INTEG: begin
                    if (isum > itop) begin
                        r_integ <= itop[aptc_pkg::INTEG_W-1:0];
                    end else if (isum < aptc_pkg::INT_FLOOR) begin
                        r_integ <= aptc_pkg::INT_FLOOR[aptc_pkg::INTEG_W-1:0];
                    end else begin
                        r_integ <= isum[aptc_pkg::INTEG_W-1:0];
                    end
                    r_state <= ST_PROP;
                end
                ST_PROP: begin
                    r_pterm <= $signed(r_prod[aptc_pkg::PT_W+3:4]);
                    r_state <= ST_ILO;
                end
                ST_ILO: begin
                    r_lo    <= r_prod[aptc_pkg::LO_W-1:0];
                    r_state <= ST_IHI;
                end
                ST_IHI: begin
                    // floor(gain * integral / 2^21) from the two partial products
                    r_iterm <= (aptc_pkg::ITERM_W'($signed(r_prod[aptc_pkg::HP_W-1:0])) <<< 3)
                             + $signed(aptc_pkg::ITERM_W'(
                                   r_lo[aptc_pkg::LO_W-1:aptc_pkg::FRAC_INT+4]));
                    r_state <= ST_DUTY;
                end
                ST_DUTY: begin
                    if (nx < 0) begin
                        r_duty_acc <= '0;
                    end else if (nx > ncap) begin
                        r_duty_acc <= ncap[aptc_pkg::DUTY_W-1:0];
                    end else begin
                        r_duty_acc <= nx[aptc_pkg::DUTY_W-1:0];
                    end
                    r_last_err <= r_err;
                    r_state    <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_o_phase <= r_phase;
                        r_o_heat  <= r_heat;
                        r_o_duty  <= r_duty_acc[aptc_pkg::DUTY_W-1:aptc_pkg::FRAC_DUTY];
                        r_o_avg   <= r_avg;
                        r_o_tens  <= r_tens;
                        r_o_ones  <= r_ones;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {6'b0, r_o_ones, r_o_tens, r_o_avg, r_o_duty};
    assign o_m_axis_tuser  = {r_o_heat, r_o_phase};

    `APTC_ASSERT_NOW(a_wpos_range, 1'b1, r_wpos <= aptc_pkg::POS_W'(aptc_pkg::WINDOW - 1), "write position out of range")
    `APTC_ASSERT_NEXT(a_filled_sticky, r_filled, r_filled, "ring fill flag dropped")
    `APTC_ASSERT_NEXT(a_accept_busy, in_acc, r_state != ST_IDLE, "sequencer idle after accept")
    `APTC_ASSERT_NEXT(a_done_load, (r_state == ST_DONE) && out_free, r_ovalid && (r_state == ST_IDLE), "result not loaded")
    `APTC_ASSERT_NOW(a_chosen_duty, r_ovalid && (r_o_phase == aptc_pkg::PH_CHOSEN), r_o_duty == 10'd0, "nonzero duty on mode choice")

endmodule

### bench/averaged_pi_temperature_controller_unit_test.sv
`timescale 1ns / 1ps

module averaged_pi_temperature_controller_unit_test;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        aptc_pkg::t_phase phase;
        bit               heating;
        bit [9:0]         duty;
        bit [15:0]        average_temp;
        bit [3:0]         tens_digit;
        bit [3:0]         ones_digit;
    } t_reading;

    class controller_mirror;
        bit [15:0]   setpoint, prop_gain, integ_gain, period, int_limit;
        bit [9:0]    heat_lim, cool_lim;
        bit [15:0]   ring [aptc_pkg::WINDOW];
        int unsigned wpos;
        bit          filled;
        int unsigned sum;
        bit          heat;
        longint      integ;
        longint      last_err;
        longint      duty_acc;
        t_reading    readings_due[$];
        int          mismatches;

        function new();
            setpoint   = 16'd240;
            prop_gain  = 16'd1638;
            integ_gain = 16'd1638;
            period     = 16'd8520;
            int_limit  = 16'd320;
            heat_lim   = 10'd256;
            cool_lim   = 10'd1023;
            wpos       = 0;
            filled     = 0;
            sum        = 0;
            heat       = 0;
            integ      = 0;
            last_err   = 0;
            duty_acc   = 0;
            mismatches = 0;
        endfunction

        function void set_reg(aptc_pkg::t_cfg_idx idx, bit [15:0] v);
            case (idx)
                aptc_pkg::CFG_SETPOINT:   setpoint   = v;
                aptc_pkg::CFG_PROP_GAIN:  prop_gain  = v;
                aptc_pkg::CFG_INTEG_GAIN: integ_gain = v;
                aptc_pkg::CFG_PERIOD:     period     = v;
                aptc_pkg::CFG_INT_LIMIT:  int_limit  = v;
                aptc_pkg::CFG_HEAT_LIM:   heat_lim   = v[9:0];
                aptc_pkg::CFG_COOL_LIM:   cool_lim   = v[9:0];
                default: ;
            endcase
        endfunction

        function void regulate(int unsigned avg);
            longint err, top, nxt, cap;
            err = longint'(setpoint) - longint'(avg);
            if (!heat)
                err = -err;
            integ = integ + longint'(period) * (last_err + err);
            top = longint'(int_limit) << aptc_pkg::FRAC_INT;
            if (integ > top)
                integ = top;
            if (integ < -(64'sd1 <<< (aptc_pkg::INTEG_W - 1)))
                integ = -(64'sd1 <<< (aptc_pkg::INTEG_W - 1));
            nxt = duty_acc + ((longint'(prop_gain) * err) >>> 4)
                + ((longint'(integ_gain) * integ) >>> (aptc_pkg::FRAC_INT + 4));
            if (nxt < 0)
                nxt = 0;
            cap = longint'(heat ? heat_lim : cool_lim) << aptc_pkg::FRAC_DUTY;
            if (nxt > cap)
                nxt = cap;
            duty_acc = nxt;
            last_err = err;
        endfunction

        function void take_sample(bit [15:0] raw);
            int unsigned old, avg, fahr;
            bit          just;
            t_reading    r;
            old  = filled ? ring[wpos] : 0;
            just = 0;
            ring[wpos] = raw;
            sum = sum - old + raw;
            wpos++;
            if (wpos >= aptc_pkg::WINDOW) begin
                wpos   = 0;
                just   = !filled;
                filled = 1;
            end
            r = '{aptc_pkg::PH_FILL, 1'b0, 10'd0, 16'd0, 4'd0, 4'd0};
            if (filled) begin
                avg  = sum / aptc_pkg::WINDOW;
                fahr = (sum * 9 / (80 * aptc_pkg::WINDOW) + 32) & 255;
                if (just) begin
                    heat    = !(sum >= int'(setpoint) * aptc_pkg::WINDOW);
                    r.phase = aptc_pkg::PH_CHOSEN;
                end else begin
                    regulate(avg);
                    r.phase = aptc_pkg::PH_REG;
                end
                r.heating      = heat;
                r.duty         = duty_acc[aptc_pkg::FRAC_DUTY +: 10];
                r.average_temp = avg[15:0];
                r.tens_digit   = 4'((fahr / 10) % 10);
                r.ones_digit   = 4'(fahr % 10);
            end
            readings_due.push_back(r);
        endfunction

        function void match_reading(logic [aptc_pkg::TDATA_W-1:0] d,
                                    logic [aptc_pkg::TUSER_W-1:0] u);
            t_reading r;
            if (readings_due.size() == 0) begin
                $error("result item with no sample waiting: tdata %h tuser %h", d, u);
                mismatches++;
                return;
            end
            r = readings_due.pop_front();
            if (u[1:0] !== r.phase) begin
                $error("phase: expected %0d, got %0d", r.phase, u[1:0]);
                mismatches++;
            end
            if (u[2] !== r.heating) begin
                $error("heating: expected %0d, got %0d", r.heating, u[2]);
                mismatches++;
            end
            if (d[9:0] !== r.duty) begin
                $error("duty: expected %0d, got %0d", r.duty, d[9:0]);
                mismatches++;
            end
            if (d[25:10] !== r.average_temp) begin
                $error("average_temp: expected %0d, got %0d", r.average_temp, d[25:10]);
                mismatches++;
            end
            if (d[29:26] !== r.tens_digit) begin
                $error("tens_digit: expected %0d, got %0d", r.tens_digit, d[29:26]);
                mismatches++;
            end
            if (d[33:30] !== r.ones_digit) begin
                $error("ones_digit: expected %0d, got %0d", r.ones_digit, d[33:30]);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_valid   = 1'b0;
    logic [15:0]        s_data    = 16'd0;
    logic               m_ready   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = 3'd0;
    logic [15:0]        cfg_data  = 16'd0;
    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [aptc_pkg::TDATA_W-1:0] o_m_axis_tdata;
    logic [aptc_pkg::TUSER_W-1:0] o_m_axis_tuser;
    logic               o_cfg_ready;

    bit tx_burst = 0;
    bit rx_burst = 0;
    bit hold_rx  = 0;

    controller_mirror mirror = new();

    averaged_pi_temperature_controller_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("averaged_pi_temperature_controller_unit_test: errors");
        $finish;
    end

    task automatic send_sample(logic [15:0] v);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        do @(posedge clk); while (!o_s_axis_tready);
        mirror.take_sample(v);
    endtask

    task automatic write_reg(aptc_pkg::t_cfg_idx idx, logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!o_cfg_ready);
        mirror.set_reg(idx, v);
    endtask

    // wait until every result is back, then let the sequencer drain
    task automatic settle();
        @(negedge clk);
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        while (mirror.readings_due.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [15:0] pick_val(int p, int top, int lo, int hi);
        if (p == 1)
            return 16'(top);
        if (p == 2)
            return 16'd0;
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'(top);
            2: return 16'($urandom_range(0, top));
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic [15:0] make_sample(int center, int spread);
        int v;
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom_range(0, 65535));
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    initial begin
        int gap;
        wait (rst_n);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 12);
            @(negedge clk);
            if (hold_rx) begin
                hold_rx = 0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!o_m_axis_tvalid);
            mirror.match_reading(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    initial begin
        logic [15:0] edge_vals [8];
        int          center, spread;
        edge_vals = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                      16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // setpoint extreme decides the mode picked when the ring fills
        write_reg(aptc_pkg::CFG_SETPOINT, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        settle();
        for (int i = 0; i < 24; i++) begin
            if (i < 8)
                send_sample(edge_vals[i]);
            else if (i >= 20)
                send_sample(edge_vals[i - 20]);
            else
                send_sample(16'($urandom_range(0, 65535)));
        end
        settle();

        for (int p = 1; p <= PHASES; p++) begin
            write_reg(aptc_pkg::CFG_SETPOINT,   pick_val(p, 65535, 200, 800));
            write_reg(aptc_pkg::CFG_PROP_GAIN,  pick_val(p, 65535, 500, 4000));
            write_reg(aptc_pkg::CFG_INTEG_GAIN, pick_val(p, 65535, 500, 4000));
            write_reg(aptc_pkg::CFG_PERIOD,     pick_val(p, 65535, 2000, 20000));
            write_reg(aptc_pkg::CFG_INT_LIMIT,  pick_val(p, 65535, 100, 2000));
            write_reg(aptc_pkg::CFG_HEAT_LIM,   pick_val(p, 1023, 100, 1023));
            write_reg(aptc_pkg::CFG_COOL_LIM,   pick_val(p, 1023, 100, 1023));
            settle();

            tx_burst = (p % 3 == 2);
            rx_burst = (p % 4 == 3);
            center = int'(mirror.setpoint) + int'($urandom_range(0, 1000)) - 500;
            case ($urandom_range(0, 3))
                0: spread = 4;
                1: spread = 64;
                2: spread = 1024;
                default: spread = 16384;
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 3 && i == 50)
                    hold_rx = 1;
                send_sample(make_sample(center, spread));
            end
            tx_burst = 0;
            rx_burst = 0;
            settle();
        end

        repeat (40) @(negedge clk);
        if (mirror.mismatches == 0 && mirror.readings_due.size() == 0)
            $display("averaged_pi_temperature_controller_unit_test: clean");
        else
            $display("averaged_pi_temperature_controller_unit_test: errors");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/aptc_pkg.sv
src/averaged_pi_temperature_controller_unit.sv
bench/averaged_pi_temperature_controller_unit_test.sv
